// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, included by tlik_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tlik_pkg.sv =====
package tlik_pkg;

   localparam int LINK_W   = 14;
   localparam int LIM_W    = 15;
   localparam int J1_W     = 15;
   localparam int J2_W     = 14;
   localparam int STAT_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MUL_W    = 32;
   localparam int WORD_W   = 64;
   localparam int OUT_FRAC = 12;
   localparam int RSP_DATA_W = 32;

   localparam logic [LINK_W-1:0] L1_RST = 14'd2400;
   localparam logic [LINK_W-1:0] L2_RST = 14'd2400;
   localparam logic signed [LIM_W-1:0] J1_MIN_RST = -15'sd6431;
   localparam logic signed [LIM_W-1:0] J1_MAX_RST = 15'sd6431;
   localparam logic signed [LIM_W-1:0] J2_MIN_RST = 15'sd0;
   localparam logic signed [LIM_W-1:0] J2_MAX_RST = 15'sd8561;

   localparam logic signed [WORD_W-1:0] HALF_PI_Q32 = 64'sd6746518852;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 3'd0,
      STAT_FAR    = 3'd1,
      STAT_NEAR   = 3'd2,
      STAT_ORIGIN = 3'd3,
      STAT_J1     = 3'd4,
      STAT_J2     = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_L1     = 3'd0,
      CSR_L2     = 3'd1,
      CSR_J1_MIN = 3'd2,
      CSR_J1_MAX = 3'd3,
      CSR_J2_MIN = 3'd4,
      CSR_J2_MAX = 3'd5
   } csr_index_type;

   // multiplier operand selects
   typedef enum logic [3:0] {
      OP_AX, OP_AY, OP_SUM, OP_DIFF, OP_L1, OP_L2, OP_K, OP_P, OP_L1S, OP_DSQ
   } opnd_type;

   // datapath register write selects
   typedef enum logic [4:0] {
      D_NONE, D_DSQ, D_DSQ_ADD, D_SUMSQ, D_DIFFSQ, D_L1S, D_L2S, D_K,
      D_P_A, D_P_B, D_R2, D_R2_B, D_PP, D_RAD, D_Z2, D_ALPHA, D_BETA, D_T
   } dest_type;

   typedef struct packed {
      logic       load;
      opnd_type   mul_a;
      opnd_type   mul_b;
      dest_type   dest;
      logic       sqrt_start;
      logic       cord_start;
      logic       cord_xy;
      logic       out_load;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic too_far;
      logic too_close;
      logic at_origin;
      logic sqrt_done;
      logic cord_done;
   } sts_type;

   // cordic step angles atan(2^-i) in q32
   function automatic logic signed [WORD_W-1:0] step_q32(input logic [4:0] idx);
      logic signed [WORD_W-1:0] v;
      case (idx)
         5'd0:  v = 64'sd3373259426;
         5'd1:  v = 64'sd1991351318;
         5'd2:  v = 64'sd1052175346;
         5'd3:  v = 64'sd534100635;
         5'd4:  v = 64'sd268086748;
         5'd5:  v = 64'sd134174063;
         5'd6:  v = 64'sd67103403;
         5'd7:  v = 64'sd33553749;
         5'd8:  v = 64'sd16777131;
         5'd9:  v = 64'sd8388597;
         5'd10: v = 64'sd4194303;
         default: v = 64'sd1 <<< (6'd32 - {1'b0, idx});
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/tlik_isqrt.sv =====
module tlik_isqrt
   import tlik_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] radicand,
   output logic              done,
   output logic [MUL_W-1:0]  root
);

   logic [WORD_W-1:0] v_ff, v_in, r_ff, r_in, b_ff, b_in, trial;
   logic              busy_ff, busy_in, done_ff, done_in;

   // one result bit per cycle, from the top bit pair down
   always_comb begin
      trial   = r_ff + b_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = radicand;
         r_in    = '0;
         b_in    = 64'd1 << 62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[MUL_W-1:0];

endmodule

// ===== hw/rtl/tlik_cordic.sv =====
module tlik_cordic
   import tlik_pkg::*;
#(
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [WORD_W-1:0]     opnd_b,
   input  logic signed [WORD_W-1:0]     opnd_a,
   output logic                         done,
   output logic signed [ANGLE_WIDTH+2:0] angle
);

   localparam int ZW    = ANGLE_WIDTH + 3;
   localparam int SH    = 32 - ANGLE_WIDTH;
   localparam int CNT_W = $clog2(CORDIC_STEPS);
   localparam logic signed [WORD_W-1:0] RND =
      (SH == 0) ? 64'sd0 : (64'sd1 <<< ((SH == 0) ? 0 : SH - 1));
   localparam logic signed [WORD_W-1:0] LIM_FINE   = 64'sd1 <<< 52;
   localparam logic signed [WORD_W-1:0] LIM_COARSE = 64'sd1 <<< 44;

   function automatic logic signed [WORD_W-1:0] from_q32(input logic signed [WORD_W-1:0] v);
      return (v + RND) >>> SH;
   endfunction

   localparam logic signed [ZW-1:0] HALF_PI = ZW'(from_q32(HALF_PI_Q32));

   typedef enum logic [1:0] {CS_IDLE, CS_NORM, CS_ROT} cstate_type;

   cstate_type               state_ff, state_in;
   logic signed [WORD_W-1:0] a_ff, a_in, b_ff, b_in, da, db;
   logic signed [ZW-1:0]     z_ff, z_in, step;
   logic [CNT_W-1:0]         i_ff, i_in;
   logic                     done_ff, done_in;
   logic                     coarse, fine;

   always_comb begin
      coarse = (a_ff < LIM_COARSE) && (a_ff > -LIM_COARSE) &&
               (b_ff < LIM_COARSE) && (b_ff > -LIM_COARSE);
      fine   = (a_ff < LIM_FINE) && (a_ff > -LIM_FINE) &&
               (b_ff < LIM_FINE) && (b_ff > -LIM_FINE);
      step   = ZW'(from_q32(step_q32(5'(i_ff))));
      da     = b_ff >>> i_ff;
      db     = a_ff >>> i_ff;
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            if (start) begin
               a_in = opnd_a;
               b_in = opnd_b;
               z_in = '0;
               i_in = '0;
               if (opnd_a == '0 && opnd_b == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = CS_NORM;
               end
            end
         end
         CS_NORM: begin
            // doubling is exact, so eight at a time while far from the limit
            if (coarse) begin
               a_in = a_ff <<< 8;
               b_in = b_ff <<< 8;
            end else if (fine) begin
               a_in = a_ff <<< 1;
               b_in = b_ff <<< 1;
            end else begin
               state_in = CS_ROT;
               if (a_ff < 0) begin
                  if (b_ff >= 0) begin
                     a_in = b_ff;
                     b_in = -a_ff;
                     z_in = HALF_PI;
                  end else begin
                     a_in = -b_ff;
                     b_in = a_ff;
                     z_in = -HALF_PI;
                  end
               end
            end
         end
         CS_ROT: begin
            if (b_ff >= 0) begin
               a_in = a_ff + da;
               b_in = b_ff - db;
               z_in = z_ff + step;
            end else begin
               a_in = a_ff - da;
               b_in = b_ff + db;
               z_in = z_ff - step;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = CS_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      z_ff <= z_in;
      i_ff <= i_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

// ===== hw/rtl/tlik_dp.sv =====
module tlik_dp
   import tlik_pkg::*;
#(
   parameter int COORD_WIDTH  = 16,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   input  logic                          csr_valid,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   input  logic signed [COORD_WIDTH-1:0] req_x,
   input  logic signed [COORD_WIDTH-1:0] req_y,
   output logic signed [J1_W-1:0]        rsp_t1,
   output logic [J2_W-1:0]               rsp_t2,
   output status_type                    rsp_status
);

   localparam int ZW = ANGLE_WIDTH + 3;
   localparam int DW = ANGLE_WIDTH + 4;
   localparam int RS = ANGLE_WIDTH - OUT_FRAC;
   localparam logic signed [DW-1:0] RND_T =
      (RS == 0) ? DW'(0) : (DW'(1) <<< ((RS == 0) ? 0 : RS - 1));

   logic [LINK_W-1:0]          l1_ff, l2_ff;
   logic signed [LIM_W-1:0]    j1_min_ff, j1_max_ff, j2_min_ff, j2_max_ff;
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff;
   logic [WORD_W-1:0]          prod_ff, dsq_ff, sumsq_ff, diffsq_ff, r2_ff, pp_ff, rad_ff;
   logic [2*LINK_W-1:0]        l1s_ff, l2s_ff;
   logic [2*LINK_W:0]          k_ff;
   logic signed [WORD_W-1:0]   p_ff;
   logic signed [ZW-1:0]       z2_ff, alpha_ff, beta_ff, cz, cz_clamp;
   logic signed [DW-1:0]       t1_ff, t2_ff, ang_diff;
   logic signed [J1_W-1:0]     out_t1_ff;
   logic [J2_W-1:0]            out_t2_ff;
   status_type                 out_status_ff, lim_code, code;

   logic [COORD_WIDTH-1:0]     ax, ay;
   logic [LINK_W:0]            sum;
   logic [LINK_W-1:0]          diff;
   logic [WORD_W-1:0]          pmag;
   logic [MUL_W-1:0]           mul_a, mul_b, root;
   logic                       sqrt_done, cord_done;
   logic signed [WORD_W-1:0]   cord_a, cord_b;

   function automatic logic [MUL_W-1:0] pick(input opnd_type sel,
                                             input logic [MUL_W-1:0] v_ax,
                                             input logic [MUL_W-1:0] v_ay,
                                             input logic [MUL_W-1:0] v_sum,
                                             input logic [MUL_W-1:0] v_diff,
                                             input logic [MUL_W-1:0] v_l1,
                                             input logic [MUL_W-1:0] v_l2,
                                             input logic [MUL_W-1:0] v_k,
                                             input logic [MUL_W-1:0] v_p,
                                             input logic [MUL_W-1:0] v_l1s,
                                             input logic [MUL_W-1:0] v_dsq);
      logic [MUL_W-1:0] r;
      case (sel)
         OP_AX:   r = v_ax;
         OP_AY:   r = v_ay;
         OP_SUM:  r = v_sum;
         OP_DIFF: r = v_diff;
         OP_L1:   r = v_l1;
         OP_L2:   r = v_l2;
         OP_K:    r = v_k;
         OP_P:    r = v_p;
         OP_L1S:  r = v_l1s;
         default: r = v_dsq;
      endcase
      return r;
   endfunction

   always_comb begin
      ax   = x_ff[COORD_WIDTH-1] ? COORD_WIDTH'(-x_ff) : COORD_WIDTH'(x_ff);
      ay   = y_ff[COORD_WIDTH-1] ? COORD_WIDTH'(-y_ff) : COORD_WIDTH'(y_ff);
      sum  = {1'b0, l1_ff} + {1'b0, l2_ff};
      diff = (l1_ff > l2_ff) ? l1_ff - l2_ff : l2_ff - l1_ff;
      pmag = p_ff[WORD_W-1] ? WORD_W'(-p_ff) : WORD_W'(p_ff);
      mul_a = pick(cmd.mul_a, MUL_W'(ax), MUL_W'(ay), MUL_W'(sum), MUL_W'(diff),
                   MUL_W'(l1_ff), MUL_W'(l2_ff), MUL_W'(k_ff), pmag[MUL_W-1:0],
                   MUL_W'(l1s_ff), dsq_ff[MUL_W-1:0]);
      mul_b = pick(cmd.mul_b, MUL_W'(ax), MUL_W'(ay), MUL_W'(sum), MUL_W'(diff),
                   MUL_W'(l1_ff), MUL_W'(l2_ff), MUL_W'(k_ff), pmag[MUL_W-1:0],
                   MUL_W'(l1s_ff), dsq_ff[MUL_W-1:0]);
      cord_a = cmd.cord_xy ? WORD_W'(x_ff) : p_ff;
      cord_b = cmd.cord_xy ? WORD_W'(y_ff) : $signed({{(WORD_W-MUL_W){1'b0}}, root});
      cz_clamp = cz[ZW-1] ? '0 : cz;
      ang_diff = DW'(alpha_ff) - DW'(beta_ff);
      if (t1_ff < DW'(j1_min_ff) || t1_ff > DW'(j1_max_ff)) begin
         lim_code = STAT_J1;
      end else if (t2_ff < DW'(j2_min_ff) || t2_ff > DW'(j2_max_ff)) begin
         lim_code = STAT_J2;
      end else begin
         lim_code = STAT_OK;
      end
      code = (cmd.status != STAT_OK) ? cmd.status : lim_code;
   end

   tlik_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (rad_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   tlik_cordic #(
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.cord_start),
      .opnd_b (cord_b),
      .opnd_a (cord_a),
      .done   (cord_done),
      .angle  (cz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff     <= L1_RST;
         l2_ff     <= L2_RST;
         j1_min_ff <= J1_MIN_RST;
         j1_max_ff <= J1_MAX_RST;
         j2_min_ff <= J2_MIN_RST;
         j2_max_ff <= J2_MAX_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_L1:     l1_ff     <= csr_data[LINK_W-1:0];
            CSR_L2:     l2_ff     <= csr_data[LINK_W-1:0];
            CSR_J1_MIN: j1_min_ff <= csr_data[LIM_W-1:0];
            CSR_J1_MAX: j1_max_ff <= csr_data[LIM_W-1:0];
            CSR_J2_MIN: j2_min_ff <= csr_data[LIM_W-1:0];
            CSR_J2_MAX: j2_max_ff <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= WORD_W'(mul_a * mul_b);
      if (cmd.load) begin
         x_ff <= req_x;
         y_ff <= req_y;
      end
      case (cmd.dest)
         D_DSQ:     dsq_ff    <= prod_ff;
         D_DSQ_ADD: dsq_ff    <= dsq_ff + prod_ff;
         D_SUMSQ:   sumsq_ff  <= prod_ff;
         D_DIFFSQ:  diffsq_ff <= prod_ff;
         D_L1S:     l1s_ff    <= prod_ff[2*LINK_W-1:0];
         D_L2S:     l2s_ff    <= prod_ff[2*LINK_W-1:0];
         D_K:       k_ff      <= {prod_ff[2*LINK_W-1:0], 1'b0};
         D_P_A:     p_ff <= $signed(dsq_ff) - $signed(WORD_W'(l1s_ff))
                            - $signed(WORD_W'(l2s_ff));
         D_P_B:     p_ff <= $signed(WORD_W'(l1s_ff)) + $signed(dsq_ff)
                            - $signed(WORD_W'(l2s_ff));
         D_R2:      r2_ff  <= prod_ff;
         D_R2_B:    r2_ff  <= prod_ff << 2;
         D_PP:      pp_ff  <= prod_ff;
         // argument outside [-1,1] clamps through a zero sqrt term
         D_RAD:     rad_ff <= (pp_ff <= r2_ff) ? r2_ff - pp_ff : '0;
         D_Z2:      z2_ff    <= cz_clamp;
         D_ALPHA:   alpha_ff <= cz;
         D_BETA:    beta_ff  <= cz_clamp;
         D_T: begin
            t1_ff <= (ang_diff + RND_T) >>> RS;
            t2_ff <= (DW'(z2_ff) + RND_T) >>> RS;
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         out_status_ff <= code;
         out_t1_ff     <= (code == STAT_OK) ? t1_ff[J1_W-1:0] : '0;
         out_t2_ff     <= (code == STAT_OK) ? t2_ff[J2_W-1:0] : '0;
      end
   end

   always_comb begin
      sts.too_far   = dsq_ff > sumsq_ff;
      sts.too_close = dsq_ff < diffsq_ff;
      sts.at_origin = dsq_ff == '0;
      sts.sqrt_done = sqrt_done;
      sts.cord_done = cord_done;
   end

   assign rsp_t1     = out_t1_ff;
   assign rsp_t2     = out_t2_ff;
   assign rsp_status = out_status_ff;

endmodule

// ===== hw/rtl/tlik_ctrl.sv =====
module tlik_ctrl
   import tlik_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

`include "assert_macros.svh"

   typedef enum logic [4:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_MUL6, S_MUL7,
      S_PA, S_R2A, S_AC_MUL, S_AC_PP, S_AC_RAD, S_SQ_GO, S_SQ_WAIT,
      S_CO_GO, S_CO_WAIT, S_B0, S_B1, S_FIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {PH_ACOS2, PH_ALPHA, PH_BETA} phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      status_in = status_ff;
      cmd.load       = 1'b0;
      cmd.mul_a      = OP_AX;
      cmd.mul_b      = OP_AX;
      cmd.dest       = D_NONE;
      cmd.sqrt_start = 1'b0;
      cmd.cord_start = 1'b0;
      cmd.cord_xy    = phase_ff == PH_ALPHA;
      cmd.out_load   = 1'b0;
      cmd.status     = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_a = OP_AX; cmd.mul_b = OP_AX;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.dest = D_DSQ; cmd.mul_a = OP_AY; cmd.mul_b = OP_AY;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.dest = D_DSQ_ADD; cmd.mul_a = OP_SUM; cmd.mul_b = OP_SUM;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.dest = D_SUMSQ; cmd.mul_a = OP_DIFF; cmd.mul_b = OP_DIFF;
            state_in = S_MUL4;
         end
         S_MUL4: begin
            cmd.dest = D_DIFFSQ; cmd.mul_a = OP_L1; cmd.mul_b = OP_L1;
            state_in = S_MUL5;
         end
         S_MUL5: begin
            cmd.dest = D_L1S; cmd.mul_a = OP_L2; cmd.mul_b = OP_L2;
            state_in = S_MUL6;
         end
         S_MUL6: begin
            cmd.dest = D_L2S; cmd.mul_a = OP_L1; cmd.mul_b = OP_L2;
            state_in = S_MUL7;
         end
         S_MUL7: begin
            // reach checks in priority order
            cmd.dest = D_K;
            if (sts.too_far) begin
               status_in = STAT_FAR;
               state_in  = S_OUT;
            end else if (sts.too_close) begin
               status_in = STAT_NEAR;
               state_in  = S_OUT;
            end else if (sts.at_origin) begin
               status_in = STAT_ORIGIN;
               state_in  = S_OUT;
            end else begin
               status_in = STAT_OK;
               state_in  = S_PA;
            end
         end
         S_PA: begin
            cmd.dest = D_P_A; cmd.mul_a = OP_K; cmd.mul_b = OP_K;
            state_in = S_R2A;
         end
         S_R2A: begin
            cmd.dest = D_R2;
            phase_in = PH_ACOS2;
            state_in = S_AC_MUL;
         end
         S_AC_MUL: begin
            cmd.mul_a = OP_P; cmd.mul_b = OP_P;
            state_in = S_AC_PP;
         end
         S_AC_PP: begin
            cmd.dest = D_PP;
            state_in = S_AC_RAD;
         end
         S_AC_RAD: begin
            cmd.dest = D_RAD;
            state_in = S_SQ_GO;
         end
         S_SQ_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (sts.sqrt_done) begin
               state_in = S_CO_GO;
            end
         end
         S_CO_GO: begin
            cmd.cord_start = 1'b1;
            state_in = S_CO_WAIT;
         end
         S_CO_WAIT: begin
            if (sts.cord_done) begin
               case (phase_ff)
                  PH_ACOS2: begin
                     cmd.dest = D_Z2;
                     phase_in = PH_ALPHA;
                     state_in = S_CO_GO;
                  end
                  PH_ALPHA: begin
                     cmd.dest = D_ALPHA;
                     state_in = S_B0;
                  end
                  default: begin
                     cmd.dest = D_BETA;
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_B0: begin
            cmd.dest = D_P_B; cmd.mul_a = OP_L1S; cmd.mul_b = OP_DSQ;
            state_in = S_B1;
         end
         S_B1: begin
            cmd.dest = D_R2_B;
            phase_in = PH_BETA;
            state_in = S_AC_MUL;
         end
         S_FIN: begin
            cmd.dest = D_T;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_ACOS2;
         status_ff    <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_NEVER(a_rsp_overwrite, clock, reset, cmd.out_load && rsp_valid_ff && !rsp_tready, "result word overwritten")
   `ASSERT_NEVER(a_sqrt_stray, clock, reset, sts.sqrt_done && state_ff != S_SQ_WAIT, "sqrt done outside wait")
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == S_MUL0, "accepted word did not start")

endmodule

// ===== hw/rtl/two_link_inverse_kinematics.sv =====
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: target_x, target_y
// rsp     | out | rsp_tvalid/rsp_tready | tdata: joint_one_angle, joint_two_angle; tuser: status
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
// one word in flight; the time per word is set by the bit-serial square root and the
// iterative cordic unit. a reach failure returns early, without using either unit.
// reset is synchronous and restores the register defaults; csr_ready is always high.
// a finished result waits in the output register; the next word is taken once it is stored.
module two_link_inverse_kinematics
   import tlik_pkg::*;
#(
   parameter int COORD_WIDTH  = 16,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // target_x, target_y
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // joint_one_angle, joint_two_angle
   output logic [RSP_DATA_W-1:0]                rsp_tdata,
   // status
   output logic [STAT_W-1:0]                    rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [CSR_DATA_W-1:0]                csr_data
);

   cmd_type               cmd;
   sts_type               sts;
   logic signed [J1_W-1:0] t1;
   logic [J2_W-1:0]       t2;
   status_type            status;

   tlik_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tlik_dp #(
      .COORD_WIDTH  (COORD_WIDTH),
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_x      (req_tdata[COORD_WIDTH-1:0]),
      .req_y      (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .rsp_t1     (t1),
      .rsp_t2     (t2),
      .rsp_status (status)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {{(RSP_DATA_W-J1_W-J2_W){1'b0}}, t2, t1};
   assign rsp_tuser = status;

endmodule
